// ----- hw/rtl/kmer_count_hash_table_unit_macros.svh -----
// Assertion macros shared by the checker of the k-mer counting hash table.
// No dependencies; include by bare file name inside a module body.
`ifndef KMER_COUNT_HASH_TABLE_UNIT_MACROS_SVH
`define KMER_COUNT_HASH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define KMERHT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define KMERHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/kmerht_pkg.sv -----
// Shared types and constants of the k-mer counting hash table.
// No dependencies.
`default_nettype none
package kmerht_pkg;

  localparam int KEY_W     = 64;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int REM_BITS  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_LIMIT     = 1'b1;

  localparam logic [CFG_W-1:0] BUCKET_MODULUS_RESET = 11'd1021;
  localparam logic [CFG_W-1:0] NODE_LIMIT_RESET     = 11'd1024;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] ST_COUNTED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_READ_DONE = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] kmer_key;
    logic [9:0]       entry_index;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             entry_valid;
    logic [KEY_W-1:0] entry_key;
    logic [31:0]      entry_count;
  } rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kmerht_rem_unit.sv -----
// Iterative remainder unit: 64-bit key modulo an 11-bit divisor,
// four key bits per cycle. Depends on kmerht_pkg.
`default_nettype none
module kmerht_rem_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [kmerht_pkg::KEY_W-1:0] dividend,
  input  logic [kmerht_pkg::CFG_W-1:0] divisor,
  output logic                         done,
  output logic [kmerht_pkg::CFG_W-1:0] rem
);
  import kmerht_pkg::*;

  localparam int STEPS = KEY_W / REM_BITS;
  localparam int CNT_W = $clog2(STEPS);

  logic [KEY_W-1:0] shreg;
  logic [CFG_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [CFG_W-1:0] rem_next;

  // The partial remainder stays below the divisor, so one compare and
  // subtract per key bit keeps it in range.
  always_comb begin
    logic [CFG_W:0]   t;
    logic [CFG_W-1:0] r;
    r = rem;
    for (int i = 0; i < REM_BITS; i++) begin
      t = {r, shreg[KEY_W-1-i]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      r = t[CFG_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg   <= dividend;
        dvs     <= divisor;
        rem     <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem   <= rem_next;
        shreg <= shreg << REM_BITS;
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/kmer_count_hash_table_unit.sv -----
// Top level of the k-mer counting hash table: sequencer, bucket head and node memories.
// Depends on kmerht_pkg and kmerht_rem_unit.
// A transaction is taken when start is high and busy is low; its single result appears
// for one cycle with done high and cannot be held off. Insert waits in S_MODW while the
// remainder unit forms the bucket hash, reads the bucket head in S_HEAD and S_HLOAD,
// walks the chain one node memory read at a time through S_CHK and S_NODE, and links a
// new key through S_NEW1 and S_NEW2. Read issues the node read in S_RD and answers from
// the registered read data, an unused type answers straight from idle, and clear sweeps
// the bucket head memory one entry a cycle. After reset the same sweep runs with busy
// high and no result.
`default_nettype none
module kmer_count_hash_table_unit #(
  parameter int BUCKET_DEPTH = 1024,
  parameter int POOL_DEPTH   = 1024,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  kmerht_pkg::req_t                 req,
  output logic                             done,
  output kmerht_pkg::rsp_t                 rsp,
  input  logic                             cfg_we,
  input  logic [kmerht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmerht_pkg::CFG_W-1:0]     cfg_wdata
);
  import kmerht_pkg::*;

  localparam int PW = $clog2(POOL_DEPTH);
  localparam int BW = $clog2(BUCKET_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLR   = 10'b0000000010,
    S_MODW  = 10'b0000000100,
    S_HEAD  = 10'b0000001000,
    S_HLOAD = 10'b0000010000,
    S_CHK   = 10'b0000100000,
    S_NODE  = 10'b0001000000,
    S_NEW1  = 10'b0010000000,
    S_NEW2  = 10'b0100000000,
    S_RD    = 10'b1000000000
  } state_t;

  state_t state;
  logic   rd_wait;

  logic [CFG_W-1:0] bucket_modulus;
  logic [CFG_W-1:0] node_limit;
  logic [CFG_W-1:0] next_free;
  logic [PW-1:0]    spare;
  logic             frozen;
  req_t             req_q;
  logic [BW-1:0]    bucket;
  logic [PW-1:0]    cur;
  logic [PW-1:0]    tail;
  logic [BW-1:0]    clr_cnt;
  logic             clr_report;

  logic [PW-1:0]          heads [BUCKET_DEPTH];
  logic [KEY_W-1:0]       node_keys [POOL_DEPTH];
  logic [COUNT_WIDTH-1:0] node_counts [POOL_DEPTH];
  logic [PW-1:0]          node_links [POOL_DEPTH];

  logic [PW-1:0]          head_q;
  logic [KEY_W-1:0]       key_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [PW-1:0]          link_q;

  logic [CFG_W-1:0] mod_eff;
  logic             rem_start;
  logic             rem_done;
  logic [CFG_W-1:0] rem;
  logic             accept;
  logic             pool_empty;
  logic             do_reserve;
  logic             key_match;

  logic                   count_we;
  logic [PW-1:0]          count_addr;
  logic [COUNT_WIDTH-1:0] count_wdata;
  logic                   link_we;
  logic [PW-1:0]          link_addr;
  logic [PW-1:0]          link_wdata;
  logic                   head_we;
  logic [BW-1:0]          head_addr;
  logic [PW-1:0]          head_wdata;
  logic [PW-1:0]          rd_addr;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    if (bucket_modulus == '0) begin
      mod_eff = CFG_W'(1);
    end else if (32'(bucket_modulus) > BUCKET_DEPTH) begin
      mod_eff = CFG_W'(BUCKET_DEPTH);
    end else begin
      mod_eff = bucket_modulus;
    end
  end

  assign pool_empty = (32'(next_free) >= 32'(node_limit)) || (32'(next_free) >= POOL_DEPTH);
  assign rem_start  = accept && (req.req_type == REQ_INSERT);
  assign do_reserve = rem_start && (spare == '0) && !pool_empty;
  assign key_match  = (key_q == req_q.kmer_key);

  kmerht_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (req.kmer_key),
    .divisor  (mod_eff),
    .done     (rem_done),
    .rem      (rem)
  );

  // Write ports of the memories.
  always_comb begin
    count_we    = 1'b0;
    count_addr  = cur;
    count_wdata = count_q + 1'b1;
    if (do_reserve) begin
      count_we    = 1'b1;
      count_addr  = PW'(next_free);
      count_wdata = '0;
    end else if (state == S_NODE && key_match && !(&count_q)) begin
      count_we = 1'b1;
    end else if (state == S_NEW1) begin
      count_we    = 1'b1;
      count_addr  = spare;
      count_wdata = COUNT_WIDTH'(1);
    end

    link_we    = 1'b0;
    link_addr  = spare;
    link_wdata = '0;
    if (state == S_NEW1) begin
      link_we = 1'b1;
    end else if (state == S_NEW2 && tail != '0) begin
      link_we    = 1'b1;
      link_addr  = tail;
      link_wdata = spare;
    end

    head_we    = 1'b0;
    head_addr  = bucket;
    head_wdata = spare;
    if (state == S_CLR) begin
      head_we    = 1'b1;
      head_addr  = clr_cnt;
      head_wdata = '0;
    end else if (state == S_NEW2 && tail == '0) begin
      head_we = 1'b1;
    end

    rd_addr = (state == S_RD) ? PW'(req_q.entry_index) : cur;
  end

  always_ff @(posedge clk) begin
    if (count_we) begin
      node_counts[count_addr] <= count_wdata;
    end
    if (link_we) begin
      node_links[link_addr] <= link_wdata;
    end
    if (state == S_NEW1) begin
      node_keys[spare] <= req_q.kmer_key;
    end
    if (head_we) begin
      heads[head_addr] <= head_wdata;
    end
    count_q <= node_counts[rd_addr];
    link_q  <= node_links[rd_addr];
    key_q   <= node_keys[rd_addr];
    head_q  <= heads[bucket];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      rd_wait        <= 1'b0;
      clr_cnt        <= '0;
      clr_report     <= 1'b0;
      done           <= 1'b0;
      next_free      <= CFG_W'(1);
      spare          <= '0;
      frozen         <= 1'b0;
      bucket_modulus <= BUCKET_MODULUS_RESET;
      node_limit     <= NODE_LIMIT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BUCKET_MODULUS: bucket_modulus <= cfg_wdata;
          REG_NODE_LIMIT:     node_limit     <= cfg_wdata;
          default:            ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            case (req.req_type)
              REQ_INSERT: begin
                tail <= '0;
                if (spare == '0) begin
                  if (pool_empty) begin
                    frozen <= 1'b1;
                  end else begin
                    spare     <= PW'(next_free);
                    next_free <= next_free + 1'b1;
                  end
                end
                state <= S_MODW;
              end
              REQ_READ: begin
                rd_wait <= 1'b1;
                state   <= S_RD;
              end
              REQ_CLEAR: begin
                next_free  <= CFG_W'(1);
                spare      <= '0;
                frozen     <= 1'b0;
                clr_cnt    <= '0;
                clr_report <= 1'b1;
                state      <= S_CLR;
              end
              default: begin
                done  <= 1'b1;
                rsp   <= '{status: ST_READ_DONE, entry_valid: 1'b0,
                           entry_key: '0, entry_count: '0};
              end
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == BW'(BUCKET_DEPTH - 1)) begin
            state <= S_IDLE;
            if (clr_report) begin
              done <= 1'b1;
              rsp  <= '{status: ST_CLEARED, entry_valid: 1'b0,
                        entry_key: '0, entry_count: '0};
            end
          end
        end
        S_MODW: begin
          if (rem_done) begin
            bucket <= BW'(rem);
            state  <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_HLOAD;
        end
        S_HLOAD: begin
          cur   <= head_q;
          state <= S_CHK;
        end
        S_CHK: begin
          if (cur == '0) begin
            if (frozen || spare == '0) begin
              done  <= 1'b1;
              rsp   <= '{status: ST_REJECTED, entry_valid: 1'b0,
                         entry_key: '0, entry_count: '0};
              state <= S_IDLE;
            end else begin
              state <= S_NEW1;
            end
          end else begin
            state <= S_NODE;
          end
        end
        S_NODE: begin
          if (key_match) begin
            done  <= 1'b1;
            rsp   <= '{status: ST_COUNTED, entry_valid: 1'b0,
                       entry_key: '0, entry_count: '0};
            state <= S_IDLE;
          end else begin
            tail  <= cur;
            cur   <= link_q;
            state <= S_CHK;
          end
        end
        S_NEW1: begin
          state <= S_NEW2;
        end
        S_NEW2: begin
          spare <= '0;
          done  <= 1'b1;
          rsp   <= '{status: ST_INSERTED, entry_valid: 1'b0,
                     entry_key: '0, entry_count: '0};
          state <= S_IDLE;
        end
        S_RD: begin
          // While rd_wait is set the node read is issued; once it clears, the registered read data is seen.
          if (rd_wait) begin
            rd_wait <= 1'b0;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (req_q.entry_index != '0 && 11'(req_q.entry_index) < next_free &&
                32'(req_q.entry_index) < POOL_DEPTH && count_q != '0) begin
              rsp <= '{status: ST_READ_DONE, entry_valid: 1'b1,
                       entry_key: key_q, entry_count: 32'(count_q)};
            end else begin
              rsp <= '{status: ST_READ_DONE, entry_valid: 1'b0,
                       entry_key: '0, entry_count: '0};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/kmerht_checker.sv -----
// Port-level checker of the k-mer counting hash table, bound to the top level.
// Depends on kmerht_pkg and kmer_count_hash_table_unit_macros.svh.
`default_nettype none
module kmerht_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input kmerht_pkg::rsp_t rsp
);
  import kmerht_pkg::*;
  `include "kmer_count_hash_table_unit_macros.svh"

  // A result is only shown while the block is idle.
  `KMERHT_ASSERT_NOW(a_done_not_busy, clk, rst, done, !busy)
  // An accepted transaction either occupies the block or, for the unused type,
  // answers in the next cycle.
  `KMERHT_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy != done)
  // Only a read returns entry data.
  `KMERHT_ASSERT_NOW(a_valid_on_read, clk, rst, done && rsp.entry_valid,
                     rsp.status == ST_READ_DONE)
  `KMERHT_ASSERT_NOW(a_status_range, clk, rst, done,
                     rsp.status == ST_COUNTED || rsp.status == ST_INSERTED ||
                     rsp.status == ST_REJECTED || rsp.status == ST_READ_DONE ||
                     rsp.status == ST_CLEARED)

endmodule

bind kmer_count_hash_table_unit kmerht_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the k-mer counting hash table unit.
// Depends on kmerht_pkg and kmer_count_hash_table_unit; holds its own table model.
`default_nettype none
module tb;
  import kmerht_pkg::*;

  localparam int BUCKETS    = 1024;
  localparam int POOL       = 1024;
  localparam int CYCLE_CAP  = 10000000;
  localparam int KEY_SET_SZ = 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  kmer_count_hash_table_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Table model state.
  logic [CFG_W-1:0] model_modulus;
  logic [CFG_W-1:0] model_limit;
  logic [9:0]  heads [BUCKETS];
  logic [63:0] keys_mem [POOL];
  logic [31:0] counts_mem [POOL];
  logic [9:0]  links_mem [POOL];
  int unsigned next_free;
  int unsigned spare;
  bit frozen;

  rsp_t pending_rsp [$];
  logic [63:0] key_set [KEY_SET_SZ];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int cycles = 0;
  int burst_left = 0;
  int n_inserted = 0;
  int n_rejected = 0;
  int n_counted = 0;

  function automatic void model_clear();
    for (int i = 0; i < BUCKETS; i++) heads[i] = '0;
    next_free = 1;
    spare = 0;
    frozen = 1'b0;
  endfunction

  function automatic rsp_t count_kmer(req_t r);
    rsp_t o;
    int unsigned lim, m, bucket, p, tail, steps;
    bit found;
    o = '0;
    case (r.req_type)
      REQ_INSERT: begin
        lim = (32'(model_limit) < POOL) ? 32'(model_limit) : POOL;
        if (spare == 0) begin
          if (next_free >= lim) frozen = 1'b1;
          else begin
            spare = next_free;
            next_free++;
            counts_mem[spare] = '0;
          end
        end
        m = 32'(model_modulus);
        if (m == 0) m = 1;
        if (m > BUCKETS) m = BUCKETS;
        bucket = 32'(r.kmer_key % 64'(m));
        p = 32'(heads[bucket]);
        tail = 0;
        steps = 0;
        found = 1'b0;
        while (p != 0 && p < POOL && steps < POOL && !found) begin
          if (keys_mem[p] == r.kmer_key) begin
            found = 1'b1;
            if (counts_mem[p] != 32'hFFFF_FFFF) counts_mem[p]++;
          end else begin
            tail = p;
            p = 32'(links_mem[p]);
            steps++;
          end
        end
        if (found) o.status = ST_COUNTED;
        else if (frozen || spare == 0) o.status = ST_REJECTED;
        else begin
          keys_mem[spare] = r.kmer_key;
          counts_mem[spare] = 32'd1;
          links_mem[spare] = '0;
          if (tail == 0) heads[bucket] = 10'(spare);
          else links_mem[tail] = 10'(spare);
          spare = 0;
          o.status = ST_INSERTED;
        end
      end
      REQ_READ: begin
        o.status = ST_READ_DONE;
        if (r.entry_index != 0 && 32'(r.entry_index) < next_free &&
            counts_mem[r.entry_index] != 0) begin
          o.entry_valid = 1'b1;
          o.entry_key = keys_mem[r.entry_index];
          o.entry_count = counts_mem[r.entry_index];
        end
      end
      REQ_CLEAR: begin
        model_clear();
        o.status = ST_CLEARED;
      end
      default: o.status = ST_READ_DONE;
    endcase
    return o;
  endfunction

  // Inputs change on the falling edge; acceptance is seen at the rising edge.
  task automatic send_request(input req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(count_kmer(r));
    sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BUCKET_MODULUS) model_modulus = val;
    else model_limit = val;
  endtask

  task automatic set_table(input logic [CFG_W-1:0] modulus, input logic [CFG_W-1:0] limit);
    drain();
    write_reg(REG_BUCKET_MODULUS, modulus);
    write_reg(REG_NODE_LIMIT, limit);
  endtask

  function automatic req_t make_req(logic [1:0] kind, logic [63:0] key, logic [9:0] idx);
    req_t r;
    r.req_type = kind;
    r.kmer_key = key;
    r.entry_index = idx;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: run exceeded cycle limit", $time);
      $display("status: fail");
      $finish;
    end
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        checked++;
        if (rsp.status == ST_INSERTED) n_inserted++;
        if (rsp.status == ST_REJECTED) n_rejected++;
        if (rsp.status == ST_COUNTED) n_counted++;
        if (rsp.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, rsp.status);
          errors++;
        end
        if (rsp.entry_valid !== want.entry_valid) begin
          $display("%0t: entry_valid exp %0d got %0d", $time, want.entry_valid,
                   rsp.entry_valid);
          errors++;
        end
        if (rsp.entry_key !== want.entry_key) begin
          $display("%0t: entry_key exp %h got %h", $time, want.entry_key, rsp.entry_key);
          errors++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                   rsp.entry_count);
          errors++;
        end
      end
    end
  end

  // Extremes of every field, every request kind and the pool running dry.
  task automatic test_directed();
    send_request(make_req(REQ_INSERT, 64'd0, 10'd0));
    send_request(make_req(REQ_INSERT, '1, 10'h3FF));
    send_request(make_req(REQ_INSERT, 64'd1021, 10'd0));
    send_request(make_req(REQ_INSERT, 64'd0, 10'd0));
    send_request(make_req(REQ_READ, '1, 10'd0));
    send_request(make_req(REQ_READ, 64'd0, 10'd1));
    send_request(make_req(REQ_READ, 64'd0, 10'd2));
    send_request(make_req(REQ_READ, 64'd0, 10'd3));
    send_request(make_req(REQ_READ, 64'd0, 10'h3FF));
    send_request(make_req(2'd3, '1, 10'h3FF));
    // A tiny pool freezes keys; known keys still count.
    set_table(11'd2, 11'd3);
    send_request(make_req(REQ_CLEAR, 64'd0, 10'd0));
    send_request(make_req(REQ_INSERT, 64'd10, 10'd0));
    send_request(make_req(REQ_INSERT, 64'd12, 10'd0));
    send_request(make_req(REQ_INSERT, 64'd14, 10'd0));
    send_request(make_req(REQ_INSERT, 64'd10, 10'd0));
    send_request(make_req(REQ_READ, 64'd0, 10'd3));
    send_request(make_req(REQ_READ, 64'd0, 10'd2));
    // Out-of-range register values: modulus 0 acts as one, large limit caps at pool.
    set_table(11'd0, 11'd0);
    send_request(make_req(REQ_INSERT, 64'h5555_AAAA_5555_AAAA, 10'd0));
    send_request(make_req(REQ_CLEAR, 64'd0, 10'd0));
    send_request(make_req(REQ_INSERT, 64'd7, 10'd0));
    set_table(11'h7FF, 11'h7FF);
    send_request(make_req(REQ_CLEAR, '1, 10'h3FF));
    send_request(make_req(REQ_INSERT, 64'd2048, 10'd0));
    send_request(make_req(REQ_INSERT, 64'd1024, 10'd0));
    send_request(make_req(REQ_READ, 64'd0, 10'd1));
  endtask

  // Mostly inserts over a small key set so that keys repeat and chains grow.
  task automatic test_random_phase(input logic [CFG_W-1:0] modulus,
                                   input logic [CFG_W-1:0] limit, input int count);
    int pick;
    logic [63:0] key;
    logic [9:0] idx;
    set_table(modulus, limit);
    for (int i = 0; i < KEY_SET_SZ; i++)
      key_set[i] = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4000))
                                               : {$urandom, $urandom};
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      key = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                        : key_set[$urandom_range(0, KEY_SET_SZ - 1)];
      idx = ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                        : 10'($urandom_range(0, next_free + 2));
      if (pick < 70) send_request(make_req(REQ_INSERT, key, 10'($urandom)));
      else if (pick < 94) send_request(make_req(REQ_READ, {$urandom, $urandom}, idx));
      else if (pick < 97) send_request(make_req(REQ_CLEAR, {$urandom, $urandom},
                                                10'($urandom)));
      else send_request(make_req(2'd3, {$urandom, $urandom}, 10'($urandom)));
    end
  endtask

  initial begin
    model_modulus = BUCKET_MODULUS_RESET;
    model_limit = NODE_LIMIT_RESET;
    for (int i = 0; i < POOL; i++) begin
      keys_mem[i] = '0;
      counts_mem[i] = '0;
      links_mem[i] = '0;
    end
    model_clear();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(11'd1021, 11'd1024, 110);
    test_random_phase(11'd1, 11'd1024, 80);
    test_random_phase(11'h7FF, 11'd1024, 90);
    test_random_phase(11'd7, 11'd6, 100);
    test_random_phase(11'd0, 11'd20, 90);
    test_random_phase(11'd1024, 11'h7FF, 100);
    test_random_phase(11'd13, 11'd1, 60);
    test_random_phase(11'd3, 11'd0, 60);
    test_random_phase(11'd31, 11'd40, 130);
    drain();
    repeat (40) @(negedge clk);
    $display("Sent %0d requests and checked %0d results over nine table settings.",
             sent, checked);
    $display("Results seen: %0d new keys, %0d counted, %0d rejected.",
             n_inserted, n_counted, n_rejected);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_rsp.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
